[hw/rtl/akf_pkg.sv]
// Shared types, constants and the microcode program of the altitude Kalman filter.
package akf_pkg;

    // Word format
    localparam int WORD   = 32;
    localparam int FRAC   = 16;
    localparam int ACC_W  = WORD + 4;
    localparam int REGS   = 32;
    localparam int PC_W   = 7;
    localparam int CFG_W  = 31;
    localparam int DT_W   = 21;

    // Event kinds
    localparam logic [1:0] K_PRED = 2'd0;
    localparam logic [1:0] K_BARO = 2'd1;
    localparam logic [1:0] K_GPS  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PN   = 2'd0;
    localparam logic [1:0] CFG_AN   = 2'd1;
    localparam logic [1:0] CFG_BARO = 2'd2;
    localparam logic [1:0] CFG_GPS  = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] PN_RST   = CFG_W'(655);
    localparam logic [CFG_W-1:0] AN_RST   = CFG_W'(32768);
    localparam logic [CFG_W-1:0] BARO_RST = CFG_W'(65536);
    localparam logic [CFG_W-1:0] GPS_RST  = CFG_W'(14745600);

    // Covariance reset constants
    localparam logic [WORD-1:0] C10 = WORD'(10 * (2 ** FRAC));
    localparam logic [WORD-1:0] C1  = WORD'(2 ** FRAC);
    localparam logic [WORD-1:0] C01 = WORD'((2 ** FRAC + 5) / 10);

    typedef logic [5:0] t_src;
    typedef logic [4:0] t_reg;

    // Register file slots
    localparam t_src A_H  = 6'd0;
    localparam t_src A_V  = 6'd1;
    localparam t_src A_B  = 6'd2;
    localparam t_src A_P0 = 6'd3;
    localparam t_src A_P1 = 6'd4;
    localparam t_src A_P2 = 6'd5;
    localparam t_src A_P3 = 6'd6;
    localparam t_src A_P4 = 6'd7;
    localparam t_src A_P5 = 6'd8;
    localparam t_src A_P6 = 6'd9;
    localparam t_src A_P7 = 6'd10;
    localparam t_src A_P8 = 6'd11;
    localparam t_src A_M0 = 6'd12;
    localparam t_src A_M1 = 6'd13;
    localparam t_src A_M2 = 6'd14;
    localparam t_src A_M3 = 6'd15;
    localparam t_src A_M4 = 6'd16;
    localparam t_src A_M5 = 6'd17;
    localparam t_src A_H2 = 6'd18;
    localparam t_src A_Q  = 6'd19;
    localparam t_src A_QA = 6'd20;
    localparam t_src A_S  = 6'd21;
    localparam t_src A_Y  = 6'd22;
    localparam t_src A_K0 = 6'd23;
    localparam t_src A_K1 = 6'd24;
    localparam t_src A_K2 = 6'd25;
    localparam t_src A_R0 = 6'd26;
    localparam t_src A_R1 = 6'd27;
    localparam t_src A_R2 = 6'd28;

    // Special operand sources
    localparam t_src X_VAL  = 6'd32;
    localparam t_src X_DT   = 6'd33;
    localparam t_src X_VAR  = 6'd34;
    localparam t_src X_PN   = 6'd35;
    localparam t_src X_AN   = 6'd36;
    localparam t_src X_ZERO = 6'd37;
    localparam t_src X_C10  = 6'd38;
    localparam t_src X_C1   = 6'd39;
    localparam t_src X_C01  = 6'd40;

    // Program entry points
    localparam logic [PC_W-1:0] E_RESET = 7'd0;
    localparam logic [PC_W-1:0] E_INIT  = 7'd12;
    localparam logic [PC_W-1:0] E_MEAS  = 7'd15;
    localparam logic [PC_W-1:0] E_PRED  = 7'd49;

    typedef enum logic [1:0] {
        T_PASS = 2'd0,
        T_MUL  = 2'd1,
        T_MULH = 2'd2,
        T_DIV  = 2'd3
    } t_term;

    typedef struct packed {
        t_term term;
        logic  clr;
        logic  neg;
        t_src  srca;
        t_src  srcb;
        logic  wr;
        t_reg  dst;
        logic  jle;
        logic  last;
    } t_uword;

    typedef struct packed {
        logic rd;
        logic mul;
        logic rnd;
        logic acc;
        logic div_go;
    } t_dp_ctl;

    typedef struct packed {
        logic div_done;
        logic le0;
    } t_dp_sts;

    typedef struct packed {
        logic [WORD-1:0] val;
        logic [WORD-1:0] dt;
        logic [WORD-1:0] var_r;
        logic [WORD-1:0] pn;
        logic [WORD-1:0] an;
    } t_srcs;

    typedef struct packed {
        logic [1:0]             kind;
        logic signed [WORD-1:0] value;
        logic [DT_W-1:0]        step_time;
    } t_in;

    typedef struct packed {
        logic signed [WORD-1:0] altitude;
        logic signed [WORD-1:0] velocity;
        logic                   ready_res;
    } t_out;

    // Microword builders
    function automatic t_uword uw(t_term t, logic c, logic n, t_src a, t_src b);
        t_uword u;
        u.term = t;
        u.clr  = c;
        u.neg  = n;
        u.srca = a;
        u.srcb = b;
        u.wr   = 1'b0;
        u.dst  = A_H[4:0];
        u.jle  = 1'b0;
        u.last = 1'b0;
        return u;
    endfunction

    function automatic t_uword wrt(t_uword u, t_src d);
        t_uword r;
        r     = u;
        r.wr  = 1'b1;
        r.dst = d[4:0];
        return r;
    endfunction

    function automatic t_uword fin(t_uword u);
        t_uword r;
        r      = u;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_uword jl(t_uword u);
        t_uword r;
        r     = u;
        r.jle = 1'b1;
        return r;
    endfunction

    function automatic t_uword ld(t_src a);
        return uw(T_PASS, 1'b1, 1'b0, a, X_ZERO);
    endfunction

    function automatic t_uword ad(t_src a);
        return uw(T_PASS, 1'b0, 1'b0, a, X_ZERO);
    endfunction

    function automatic t_uword sb(t_src a);
        return uw(T_PASS, 1'b0, 1'b1, a, X_ZERO);
    endfunction

    function automatic t_uword mac(t_src a, t_src b);
        return uw(T_MUL, 1'b0, 1'b0, a, b);
    endfunction

    function automatic t_uword msc(t_src a, t_src b);
        return uw(T_MUL, 1'b0, 1'b1, a, b);
    endfunction

    function automatic t_uword mul1(t_src a, t_src b);
        return uw(T_MUL, 1'b1, 1'b0, a, b);
    endfunction

    function automatic t_uword dv(t_src a, t_src b);
        return uw(T_DIV, 1'b1, 1'b0, a, b);
    endfunction

    // Control store
    function automatic t_uword akf_rom(logic [PC_W-1:0] pc);
        t_uword u;
        case (pc)
            // reset sweep of state and covariance
            7'd0:  u = wrt(ld(X_ZERO), A_H);
            7'd1:  u = wrt(ld(X_ZERO), A_V);
            7'd2:  u = wrt(ld(X_ZERO), A_B);
            7'd3:  u = wrt(ld(X_C10), A_P0);
            7'd4:  u = wrt(ld(X_ZERO), A_P1);
            7'd5:  u = wrt(ld(X_ZERO), A_P2);
            7'd6:  u = wrt(ld(X_ZERO), A_P3);
            7'd7:  u = wrt(ld(X_C1), A_P4);
            7'd8:  u = wrt(ld(X_ZERO), A_P5);
            7'd9:  u = wrt(ld(X_ZERO), A_P6);
            7'd10: u = wrt(ld(X_ZERO), A_P7);
            7'd11: u = fin(wrt(ld(X_C01), A_P8));
            // first measurement
            7'd12: u = wrt(ld(X_VAL), A_H);
            7'd13: u = wrt(ld(X_ZERO), A_V);
            7'd14: u = fin(wrt(ld(X_ZERO), A_B));
            // measurement update: innovation variance, skip if not positive
            7'd15: u = ld(A_P0);
            7'd16: u = jl(wrt(ad(X_VAR), A_S));
            7'd17: u = wrt(dv(A_P0, A_S), A_K0);
            7'd18: u = wrt(dv(A_P3, A_S), A_K1);
            7'd19: u = wrt(dv(A_P6, A_S), A_K2);
            7'd20: u = wrt(ld(A_P0), A_R0);
            7'd21: u = wrt(ld(A_P1), A_R1);
            7'd22: u = wrt(ld(A_P2), A_R2);
            7'd23: u = ld(X_VAL);
            7'd24: u = wrt(sb(A_H), A_Y);
            7'd25: u = ld(A_H);
            7'd26: u = wrt(mac(A_K0, A_Y), A_H);
            7'd27: u = ld(A_P0);
            7'd28: u = wrt(msc(A_K0, A_R0), A_P0);
            7'd29: u = ld(A_P1);
            7'd30: u = wrt(msc(A_K0, A_R1), A_P1);
            7'd31: u = ld(A_P2);
            7'd32: u = wrt(msc(A_K0, A_R2), A_P2);
            7'd33: u = ld(A_V);
            7'd34: u = wrt(mac(A_K1, A_Y), A_V);
            7'd35: u = ld(A_P3);
            7'd36: u = wrt(msc(A_K1, A_R0), A_P3);
            7'd37: u = ld(A_P4);
            7'd38: u = wrt(msc(A_K1, A_R1), A_P4);
            7'd39: u = ld(A_P5);
            7'd40: u = wrt(msc(A_K1, A_R2), A_P5);
            7'd41: u = ld(A_B);
            7'd42: u = wrt(mac(A_K2, A_Y), A_B);
            7'd43: u = ld(A_P6);
            7'd44: u = wrt(msc(A_K2, A_R0), A_P6);
            7'd45: u = ld(A_P7);
            7'd46: u = wrt(msc(A_K2, A_R1), A_P7);
            7'd47: u = ld(A_P8);
            7'd48: u = fin(wrt(msc(A_K2, A_R2), A_P8));
            // predict: step terms
            7'd49: u = wrt(uw(T_MULH, 1'b1, 1'b0, X_DT, X_DT), A_H2);
            7'd50: u = wrt(mul1(X_PN, X_DT), A_Q);
            7'd51: u = wrt(mul1(X_AN, X_DT), A_QA);
            // predict: state
            7'd52: u = ld(A_H);
            7'd53: u = mac(X_DT, A_V);
            7'd54: u = msc(A_H2, A_B);
            7'd55: u = wrt(mac(A_H2, X_VAL), A_H);
            7'd56: u = ld(A_V);
            7'd57: u = msc(X_DT, A_B);
            7'd58: u = wrt(mac(X_DT, X_VAL), A_V);
            // predict: F * P
            7'd59: u = ld(A_P0);
            7'd60: u = mac(X_DT, A_P3);
            7'd61: u = wrt(msc(A_H2, A_P6), A_M0);
            7'd62: u = ld(A_P3);
            7'd63: u = wrt(msc(X_DT, A_P6), A_M3);
            7'd64: u = ld(A_P1);
            7'd65: u = mac(X_DT, A_P4);
            7'd66: u = wrt(msc(A_H2, A_P7), A_M1);
            7'd67: u = ld(A_P4);
            7'd68: u = wrt(msc(X_DT, A_P7), A_M4);
            7'd69: u = ld(A_P2);
            7'd70: u = mac(X_DT, A_P5);
            7'd71: u = wrt(msc(A_H2, A_P8), A_M2);
            7'd72: u = ld(A_P5);
            7'd73: u = wrt(msc(X_DT, A_P8), A_M5);
            // predict: (F * P) * F' + Q
            7'd74: u = ld(A_M0);
            7'd75: u = mac(X_DT, A_M1);
            7'd76: u = msc(A_H2, A_M2);
            7'd77: u = wrt(ad(A_Q), A_P0);
            7'd78: u = ld(A_M1);
            7'd79: u = wrt(msc(X_DT, A_M2), A_P1);
            7'd80: u = wrt(ld(A_M2), A_P2);
            7'd81: u = ld(A_M3);
            7'd82: u = mac(X_DT, A_M4);
            7'd83: u = wrt(msc(A_H2, A_M5), A_P3);
            7'd84: u = ld(A_M4);
            7'd85: u = msc(X_DT, A_M5);
            7'd86: u = ad(A_Q);
            7'd87: u = wrt(ad(A_QA), A_P4);
            7'd88: u = wrt(ld(A_M5), A_P5);
            7'd89: u = ld(A_P6);
            7'd90: u = mac(X_DT, A_P7);
            7'd91: u = wrt(msc(A_H2, A_P8), A_P6);
            7'd92: u = ld(A_P7);
            7'd93: u = wrt(msc(X_DT, A_P8), A_P7);
            7'd94: u = ld(A_P8);
            7'd95: u = fin(wrt(ad(A_Q), A_P8));
            default: u = fin(ld(X_ZERO));
        endcase
        return u;
    endfunction

endpackage

[hw/rtl/akf_div.sv]
// Restoring fixed-point divider, one quotient bit per cycle, saturating result.
module akf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [akf_pkg::WORD-1:0]     i_num,
    input  logic [akf_pkg::WORD-1:0]     i_den,
    output logic                         o_done,
    output logic [akf_pkg::WORD-1:0]     o_quo
);
    localparam int W  = akf_pkg::WORD;
    localparam int QW = akf_pkg::WORD + akf_pkg::FRAC;
    localparam int CW = $clog2(QW) + 1;

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [QW-1:0]   r_num;
    logic [QW-1:0]   r_q;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_den;
    logic            r_neg;

    logic [W-1:0]    w_mag;
    logic [W:0]      w_trial;
    logic            w_bit;
    logic [QW-1:0]   w_lim;
    logic [QW-1:0]   w_m;

    assign w_mag   = i_num[W-1] ? (~i_num + W'(1)) : i_num;
    assign w_trial = {r_rem, r_num[QW-1]};
    assign w_bit   = (w_trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= QW'(w_mag) << akf_pkg::FRAC;
            r_rem <= '0;
            r_q   <= '0;
            r_den <= i_den;
            r_neg <= i_num[W-1];
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_q   <= {r_q[QW-2:0], w_bit};
            r_rem <= w_bit ? W'(w_trial - {1'b0, r_den}) : w_trial[W-1:0];
        end
    end

    // clamp to the word
    assign w_lim  = r_neg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
    assign w_m    = (r_q > w_lim) ? w_lim : r_q;
    assign o_quo  = r_neg ? (~w_m[W-1:0] + W'(1)) : w_m[W-1:0];
    assign o_done = r_done;
endmodule

[hw/rtl/akf_datapath.sv]
// Datapath: register file, rounding multiplier, accumulator and divider.
module akf_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  akf_pkg::t_uword                i_uw,
    input  akf_pkg::t_dp_ctl               i_ctl,
    input  akf_pkg::t_srcs                 i_src,
    output akf_pkg::t_dp_sts               o_sts,
    output logic signed [akf_pkg::WORD-1:0] o_h,
    output logic signed [akf_pkg::WORD-1:0] o_v
);
    localparam int W  = akf_pkg::WORD;
    localparam int F  = akf_pkg::FRAC;
    localparam int AW = akf_pkg::ACC_W;
    localparam logic signed [AW-1:0] ACC_MAX = {{(AW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {{(AW - W + 1){1'b1}}, {(W - 1){1'b0}}};
    localparam logic [2*W-1:0] RND_HALF = (2 * W)'(1) << (F - 1);

    logic [W-1:0] mem [akf_pkg::REGS];

    logic [W-1:0]            r_ra, r_rb, r_sa, r_sb;
    logic                    r_asel, r_bsel;
    logic [2*W-1:0]          r_prod;
    logic                    r_pneg;
    logic signed [W-1:0]     r_pass;
    logic signed [W-1:0]     r_term;
    logic signed [AW-1:0]    r_acc;
    logic signed [W-1:0]     r_h, r_v;

    logic signed [W-1:0]     w_opa, w_opb;
    logic [W-1:0]            w_maga, w_magb;
    logic [2*W-1:0]          w_prod;
    logic [2*W-1:0]          w_rnd, w_lim, w_m;
    logic signed [W-1:0]     w_fx;
    logic signed [W-1:0]     w_tnext;
    logic signed [W-1:0]     w_tsel;
    logic signed [AW-1:0]    w_text;
    logic signed [AW-1:0]    w_acc;
    logic signed [W-1:0]     w_sat;
    logic                    w_div_done;
    logic [W-1:0]            w_quo;

    function automatic logic [W-1:0] spec(akf_pkg::t_src s, akf_pkg::t_srcs x);
        logic [W-1:0] r;
        case (s)
            akf_pkg::X_VAL: r = x.val;
            akf_pkg::X_DT:  r = x.dt;
            akf_pkg::X_VAR: r = x.var_r;
            akf_pkg::X_PN:  r = x.pn;
            akf_pkg::X_AN:  r = x.an;
            akf_pkg::X_C10: r = akf_pkg::C10;
            akf_pkg::X_C1:  r = akf_pkg::C1;
            akf_pkg::X_C01: r = akf_pkg::C01;
            default:        r = '0;
        endcase
        return r;
    endfunction

    // operand fetch and register file write-back
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_ra   <= mem[i_uw.srca[4:0]];
            r_rb   <= mem[i_uw.srcb[4:0]];
            r_sa   <= spec(i_uw.srca, i_src);
            r_sb   <= spec(i_uw.srcb, i_src);
            r_asel <= i_uw.srca[5];
            r_bsel <= i_uw.srcb[5];
        end
        if (i_ctl.acc && i_uw.wr) begin
            mem[i_uw.dst] <= w_sat;
        end
    end

    assign w_opa  = r_asel ? r_sa : r_ra;
    assign w_opb  = r_bsel ? r_sb : r_rb;
    assign w_maga = w_opa[W-1] ? (~w_opa + W'(1)) : w_opa;
    assign w_magb = w_opb[W-1] ? (~w_opb + W'(1)) : w_opb;
    assign w_prod = (2 * W)'(w_maga) * (2 * W)'(w_magb);

    // multiply magnitudes
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= w_prod;
            r_pneg <= w_opa[W-1] ^ w_opb[W-1];
            r_pass <= w_opa;
        end
    end

    // round to nearest, saturate, apply sign
    assign w_rnd = (r_prod + RND_HALF) >> F;
    assign w_lim = r_pneg ? ((2 * W)'(1) << (W - 1)) : (((2 * W)'(1) << (W - 1)) - (2 * W)'(1));
    assign w_m   = (w_rnd > w_lim) ? w_lim : w_rnd;
    assign w_fx  = r_pneg ? (~w_m[W-1:0] + W'(1)) : w_m[W-1:0];

    always_comb begin
        case (i_uw.term)
            akf_pkg::T_PASS: w_tnext = r_pass;
            akf_pkg::T_MULH: w_tnext = w_fx >>> 1;
            default:         w_tnext = w_fx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rnd) begin
            r_term <= w_tnext;
        end
    end

    // accumulate and saturate once
    assign w_tsel = (i_uw.term == akf_pkg::T_DIV) ? w_quo : r_term;
    assign w_text = AW'(w_tsel);
    assign w_acc  = (i_uw.clr ? AW'(0) : r_acc) + (i_uw.neg ? -w_text : w_text);

    always_comb begin
        if (w_acc > ACC_MAX) begin
            w_sat = ACC_MAX[W-1:0];
        end else if (w_acc < ACC_MIN) begin
            w_sat = ACC_MIN[W-1:0];
        end else begin
            w_sat = w_acc[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            r_acc <= w_acc;
            if (i_uw.wr && (i_uw.dst == akf_pkg::A_H[4:0])) begin
                r_h <= w_sat;
            end
            if (i_uw.wr && (i_uw.dst == akf_pkg::A_V[4:0])) begin
                r_v <= w_sat;
            end
        end
    end

    akf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_ctl.div_go),
        .i_num   (w_opa),
        .i_den   (w_opb),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_sts.div_done = w_div_done;
    assign o_sts.le0      = w_sat[W-1] || (w_sat == '0);
    assign o_h            = r_h;
    assign o_v            = r_v;
endmodule

[hw/rtl/akf_seq.sv]
// Microcode sequencer: step counter, phase control and conditional exit.
module akf_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [akf_pkg::PC_W-1:0]    i_entry,
    input  akf_pkg::t_dp_sts            i_sts,
    output akf_pkg::t_uword             o_uw,
    output akf_pkg::t_dp_ctl            o_ctl,
    output logic                        o_done
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_RND  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_ACC  = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [akf_pkg::PC_W-1:0] r_pc, n_pc;
    akf_pkg::t_uword         w_uw;

    assign w_uw = akf_pkg::akf_rom(r_pc);
    assign o_uw = w_uw;

    // step through one microword: fetch, multiply, round or divide, accumulate
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        o_ctl   = '0;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_pc    = i_entry;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_ctl.rd = 1'b1;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_ctl.mul = 1'b1;
                if (w_uw.term == akf_pkg::T_DIV) begin
                    o_ctl.div_go = 1'b1;
                    n_state      = ST_DIV;
                end else begin
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                o_ctl.rnd = 1'b1;
                n_state   = ST_ACC;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_ctl.acc = 1'b1;
                if (w_uw.last || (w_uw.jle && i_sts.le0)) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_pc    = r_pc + akf_pkg::PC_W'(1);
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end
endmodule

[hw/rtl/altitude_kalman_filter.sv]
// Top level of the three-state altitude Kalman filter.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | input     | i_in_valid/o_in_stall   | t_in: kind, value, step_time
//  out     | output    | o_out_valid/i_out_stall | t_out: altitude, velocity, ready_res
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Every microcode step runs through the read, multiply, round and accumulate states
// of the single multiplier path; a divide step waits for the divider (48 quotient
// bits) in place of rounding. Predict runs 47 steps; a measurement update runs 34
// steps with 3 divides; the first measurement only loads the state; an ignored event is
// answered from the current state. After reset a 12-step sweep loads state and covariance
// into the register file from constants while the input stalls. One request is worked at
// a time; the next is taken once the previous result has moved to the output register.
module altitude_kalman_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  akf_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output akf_pkg::t_out                  o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [akf_pkg::CFG_W-1:0]      i_cfg_data
);
    localparam int W = akf_pkg::WORD;

    logic [akf_pkg::CFG_W-1:0] r_pn, r_an, r_baro, r_gps;
    logic                      r_busy, r_boot, r_kick, r_started, r_mark, r_pend;
    logic                      r_out_valid;
    akf_pkg::t_out             r_out;
    logic [W-1:0]              r_val, r_dt, r_var;

    logic                      w_acc_in;
    logic                      w_start;
    logic                      w_mark;
    logic [akf_pkg::PC_W-1:0]  w_entry;
    akf_pkg::t_srcs            w_src;
    akf_pkg::t_uword           w_uw;
    akf_pkg::t_dp_ctl          w_ctl;
    akf_pkg::t_dp_sts          w_sts;
    logic                      w_done;
    logic signed [W-1:0]       w_h, w_v;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy || r_pend;
    assign w_acc_in    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pn   <= akf_pkg::PN_RST;
            r_an   <= akf_pkg::AN_RST;
            r_baro <= akf_pkg::BARO_RST;
            r_gps  <= akf_pkg::GPS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                akf_pkg::CFG_PN:   r_pn   <= i_cfg_data;
                akf_pkg::CFG_AN:   r_an   <= i_cfg_data;
                akf_pkg::CFG_BARO: r_baro <= i_cfg_data;
                akf_pkg::CFG_GPS:  r_gps  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pick the program for the reset sweep or for an accepted request
    always_comb begin
        w_start = 1'b0;
        w_mark  = 1'b0;
        w_entry = akf_pkg::E_RESET;
        if (r_kick) begin
            w_start = 1'b1;
        end else if (w_acc_in) begin
            case (i_in.kind)
                akf_pkg::K_PRED: begin
                    if (r_started && (i_in.step_time != '0)) begin
                        w_start = 1'b1;
                        w_entry = akf_pkg::E_PRED;
                    end
                end
                akf_pkg::K_BARO, akf_pkg::K_GPS: begin
                    w_start = 1'b1;
                    w_entry = r_started ? akf_pkg::E_MEAS : akf_pkg::E_INIT;
                    w_mark  = !r_started;
                end
                default: ;
            endcase
        end
    end

    // latch request operands
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_val <= i_in.value;
            r_dt  <= W'(i_in.step_time);
            r_var <= (i_in.kind == akf_pkg::K_BARO) ? W'(r_baro) : W'(r_gps);
        end
    end

    assign w_src.val   = r_val;
    assign w_src.dt    = r_dt;
    assign w_src.var_r = r_var;
    assign w_src.pn    = W'(r_pn);
    assign w_src.an    = W'(r_an);

    // request and result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_boot      <= 1'b1;
            r_kick      <= 1'b1;
            r_started   <= 1'b0;
            r_mark      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_kick <= 1'b0;
            if (w_acc_in) begin
                if (w_start) begin
                    r_busy <= 1'b1;
                    r_mark <= w_mark;
                end else begin
                    r_pend <= 1'b1;
                end
            end
            if (w_done) begin
                r_busy <= 1'b0;
                r_mark <= 1'b0;
                if (r_boot) begin
                    r_boot <= 1'b0;
                end else begin
                    r_pend <= 1'b1;
                end
                if (r_mark) begin
                    r_started <= 1'b1;
                end
            end
            if (r_pend && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_pend && (!r_out_valid || !i_out_stall)) begin
            r_out.altitude  <= w_h;
            r_out.velocity  <= w_v;
            r_out.ready_res <= r_started;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    akf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_entry (w_entry),
        .i_sts   (w_sts),
        .o_uw    (w_uw),
        .o_ctl   (w_ctl),
        .o_done  (w_done)
    );

    akf_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uw    (w_uw),
        .i_ctl   (w_ctl),
        .i_src   (w_src),
        .o_sts   (w_sts),
        .o_h     (w_h),
        .o_v     (w_v)
    );
endmodule

[hw/rtl/akf_chk.sv]
// Port-level checker for the altitude Kalman filter, bound to the top level.
module akf_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input akf_pkg::t_out o_out
);
    // hold a result that is not taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // stall right after a request is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in work");

    // stall when reset is released, as the reset sweep starts
    a_boot_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("request taken during reset sweep");

    // initialized flag does not drop from one valid output cycle to the next
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.ready_res) |=> (!o_out_valid || o_out.ready_res))
        else $error("initialized flag dropped");
endmodule

bind altitude_kalman_filter akf_chk u_akf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
